// ===== hw/rtl/voxel_rle_varint_decoder_macros.svh =====
// Assertion macros used by the result queue of the voxel stream decoder RTL.
`ifndef VOXEL_RLE_VARINT_DECODER_MACROS_SVH
`define VOXEL_RLE_VARINT_DECODER_MACROS_SVH

// cond must never hold while out of reset
`define VRVD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// ante at one edge implies cons at the next edge
`define VRVD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/vrvd_pkg.sv =====
// Types, codes and constants of the voxel stream decoder.
`default_nettype none
package vrvd_pkg;

	localparam int unsigned MAX_DIM      = 4096;
	localparam int unsigned MAX_PALETTE  = 256;
	localparam logic [38:0] MAX_VOXELS   = 39'd1073741824;
	localparam int unsigned FIFO_DEPTH   = 4;

	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_PALETTE = 3'd1;
	localparam logic [2:0] KIND_RUN     = 3'd2;
	localparam logic [2:0] KIND_DONE    = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	localparam logic [2:0] ERR_MAGIC      = 3'd0;
	localparam logic [2:0] ERR_TRUNC_HDR  = 3'd1;
	localparam logic [2:0] ERR_SIZE       = 3'd2;
	localparam logic [2:0] ERR_PALETTE    = 3'd3;
	localparam logic [2:0] ERR_TRUNC_RUNS = 3'd4;
	localparam logic [2:0] ERR_RUN        = 3'd5;
	localparam logic [2:0] ERR_INDEX      = 3'd6;
	localparam logic [2:0] ERR_TRAILING   = 3'd7;

	typedef enum logic [3:0] {
		PH_MAGIC, PH_VX, PH_VY, PH_VZ, PH_VP, PH_PAL, PH_RUNS, PH_DONE, PH_ERR
	} phase_t;

	typedef struct packed {
		logic [2:0]  error_code;
		logic [30:0] run_length;
		logic [7:0]  run_value;
		logic [31:0] palette_color;
		logic [7:0]  palette_index;
		logic [8:0]  palette_count;
		logic [12:0] size_z;
		logic [12:0] size_y;
		logic [12:0] size_x;
		logic        last_result;
		logic [2:0]  kind;
	} res_t;

	// "AVX1"
	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		logic [7:0] m;
		case (pos)
			2'd0:    m = 8'h41;
			2'd1:    m = 8'h56;
			2'd2:    m = 8'h58;
			default: m = 8'h31;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vrvd_front.sv =====
// Front end: accepts stream bytes, parses the format and forms result words.
`default_nettype none
module vrvd_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               byte_valid,
	output logic              byte_ready,
	input  wire  [7:0]        in_byte,
	input  wire               last_byte,
	input  wire               room2,
	output logic [1:0]        push_n,
	output vrvd_pkg::res_t    res0,
	output vrvd_pkg::res_t    res1
);

	vrvd_pkg::phase_t phase_q, n_phase;
	logic [3:0]  bc_q, n_bc;
	logic [63:0] acc_q, n_acc;
	logic [12:0] dx_q, dy_q, dz_q, n_dx, n_dy, n_dz;
	logic [8:0]  etot_q, n_etot;
	logic [8:0]  ecnt_q, n_ecnt;
	logic [23:0] col_q, n_col;
	logic [30:0] vleft_q, n_vleft;
	logic        wait_q, n_wait;
	logic [25:0] xy_q;
	logic [38:0] xyz_q;

	logic        take;
	logic [63:0] vacc;
	logic [6:0]  shamt;
	logic        v_done, v_long;
	logic [55:0] len;
	vrvd_pkg::res_t r [2];
	logic [1:0]  n;

	assign byte_ready = room2 && !wait_q;
	assign take = byte_valid && byte_ready;
	assign shamt = 7'(bc_q) * 7'd7;
	assign vacc = acc_q | ({57'd0, in_byte[6:0]} << shamt);
	assign v_done = !in_byte[7];
	assign v_long = in_byte[7] && (bc_q >= 4'd9);
	assign len = vacc[63:8];

	function automatic logic [12:0] dim_or_zero(input logic [63:0] v);
		return (v != 64'd0 && v <= 64'(vrvd_pkg::MAX_DIM)) ? v[12:0] : 13'd0;
	endfunction

	function automatic vrvd_pkg::res_t mk(input logic [2:0] kind);
		vrvd_pkg::res_t t;
		t = '0;
		t.kind = kind;
		return t;
	endfunction

	function automatic vrvd_pkg::res_t mk_err(input logic [2:0] code);
		vrvd_pkg::res_t t;
		t = mk(vrvd_pkg::KIND_ERROR);
		t.error_code = code;
		return t;
	endfunction

	always_comb begin
		n_phase = phase_q;
		n_bc    = bc_q;
		n_acc   = acc_q;
		n_dx    = dx_q;
		n_dy    = dy_q;
		n_dz    = dz_q;
		n_etot  = etot_q;
		n_ecnt  = ecnt_q;
		n_col   = col_q;
		n_vleft = vleft_q;
		n_wait  = 1'b0;
		r[0]    = '0;
		r[1]    = '0;
		n       = 2'd0;
		case (phase_q)
			vrvd_pkg::PH_MAGIC: begin
				if (in_byte != vrvd_pkg::magic_byte(bc_q[1:0])) begin
					r[0] = mk_err(vrvd_pkg::ERR_MAGIC);
					n = 2'd1;
					n_phase = vrvd_pkg::PH_ERR;
				end else if (bc_q == 4'd3) begin
					n_bc = 4'd0;
					n_acc = '0;
					n_phase = vrvd_pkg::PH_VX;
				end else begin
					n_bc = bc_q + 4'd1;
				end
			end
			vrvd_pkg::PH_VX, vrvd_pkg::PH_VY, vrvd_pkg::PH_VZ, vrvd_pkg::PH_VP: begin
				n_acc = vacc;
				if (v_long) begin
					r[0] = mk_err(vrvd_pkg::ERR_TRUNC_HDR);
					n = 2'd1;
					n_phase = vrvd_pkg::PH_ERR;
				end else if (!v_done) begin
					n_bc = bc_q + 4'd1;
				end else begin
					n_bc = 4'd0;
					n_acc = '0;
					case (phase_q)
						vrvd_pkg::PH_VX: begin
							n_dx = dim_or_zero(vacc);
							n_phase = vrvd_pkg::PH_VY;
						end
						vrvd_pkg::PH_VY: begin
							n_dy = dim_or_zero(vacc);
							n_phase = vrvd_pkg::PH_VZ;
						end
						vrvd_pkg::PH_VZ: begin
							n_dz = dim_or_zero(vacc);
							n_phase = vrvd_pkg::PH_VP;
							// hold off the next byte until the product pipeline sees the new z
							n_wait = 1'b1;
						end
						default: begin
							n_etot = (vacc != 64'd0 && vacc <= 64'(vrvd_pkg::MAX_PALETTE))
								? vacc[8:0] : 9'd0;
							if (dx_q == '0 || dy_q == '0 || dz_q == '0
								|| xyz_q > vrvd_pkg::MAX_VOXELS) begin
								r[0] = mk_err(vrvd_pkg::ERR_SIZE);
								n = 2'd1;
								n_phase = vrvd_pkg::PH_ERR;
							end else if (n_etot == 9'd0) begin
								r[0] = mk_err(vrvd_pkg::ERR_PALETTE);
								n = 2'd1;
								n_phase = vrvd_pkg::PH_ERR;
							end else begin
								n_vleft = xyz_q[30:0];
								r[0] = mk(vrvd_pkg::KIND_HEADER);
								r[0].size_x = dx_q;
								r[0].size_y = dy_q;
								r[0].size_z = dz_q;
								r[0].palette_count = n_etot;
								n = 2'd1;
								n_ecnt = '0;
								n_col = '0;
								n_phase = vrvd_pkg::PH_PAL;
							end
						end
					endcase
				end
			end
			vrvd_pkg::PH_PAL: begin
				if (bc_q < 4'd3) begin
					n_col = col_q | (24'(in_byte) << {bc_q[1:0], 3'b000});
					n_bc = bc_q + 4'd1;
				end else begin
					r[0] = mk(vrvd_pkg::KIND_PALETTE);
					r[0].palette_index = ecnt_q[7:0];
					r[0].palette_color = {in_byte, col_q};
					n = 2'd1;
					n_bc = 4'd0;
					n_col = '0;
					n_ecnt = ecnt_q + 9'd1;
					if (n_ecnt >= etot_q) begin
						n_acc = '0;
						n_phase = vrvd_pkg::PH_RUNS;
					end
				end
			end
			vrvd_pkg::PH_RUNS: begin
				n_acc = vacc;
				if (v_long) begin
					r[0] = mk_err(vrvd_pkg::ERR_TRUNC_RUNS);
					n = 2'd1;
					n_phase = vrvd_pkg::PH_ERR;
				end else if (!v_done) begin
					n_bc = bc_q + 4'd1;
				end else begin
					n_bc = 4'd0;
					n_acc = '0;
					if (len == 56'd0 || len > {25'd0, vleft_q}) begin
						r[0] = mk_err(vrvd_pkg::ERR_RUN);
						n = 2'd1;
						n_phase = vrvd_pkg::PH_ERR;
					end else if ({1'b0, vacc[7:0]} >= etot_q) begin
						r[0] = mk_err(vrvd_pkg::ERR_INDEX);
						n = 2'd1;
						n_phase = vrvd_pkg::PH_ERR;
					end else begin
						r[0] = mk(vrvd_pkg::KIND_RUN);
						r[0].run_value = vacc[7:0];
						r[0].run_length = len[30:0];
						n = 2'd1;
						n_vleft = vleft_q - len[30:0];
						if (n_vleft == '0) begin
							n_phase = vrvd_pkg::PH_DONE;
						end
					end
				end
			end
			vrvd_pkg::PH_DONE: begin
				r[0] = mk_err(vrvd_pkg::ERR_TRAILING);
				n = 2'd1;
				n_phase = vrvd_pkg::PH_ERR;
			end
			default: begin
			end
		endcase

		if (last_byte) begin
			if (n_phase != vrvd_pkg::PH_ERR) begin
				r[n[0]] = (n_phase == vrvd_pkg::PH_DONE) ? mk(vrvd_pkg::KIND_DONE)
					: (n_phase == vrvd_pkg::PH_MAGIC) ? mk_err(vrvd_pkg::ERR_MAGIC)
					: (n_phase == vrvd_pkg::PH_PAL) ? mk_err(vrvd_pkg::ERR_PALETTE)
					: (n_phase == vrvd_pkg::PH_RUNS) ? mk_err(vrvd_pkg::ERR_TRUNC_RUNS)
					: mk_err(vrvd_pkg::ERR_TRUNC_HDR);
				n = n + 2'd1;
			end
			n_phase = vrvd_pkg::PH_MAGIC;
			n_bc    = '0;
			n_acc   = '0;
			n_dx    = '0;
			n_dy    = '0;
			n_dz    = '0;
			n_etot  = '0;
			n_ecnt  = '0;
			n_col   = '0;
			n_vleft = '0;
			n_wait  = 1'b0;
		end
		if (n == 2'd2) begin
			r[1].last_result = 1'b1;
		end else begin
			r[0].last_result = 1'b1;
		end
	end

	assign push_n = take ? n : 2'd0;
	assign res0 = r[0];
	assign res1 = r[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= vrvd_pkg::PH_MAGIC;
			bc_q    <= '0;
			acc_q   <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
			dz_q    <= '0;
			etot_q  <= '0;
			ecnt_q  <= '0;
			col_q   <= '0;
			vleft_q <= '0;
			wait_q  <= 1'b0;
		end else begin
			wait_q <= 1'b0;
			if (take) begin
				phase_q <= n_phase;
				bc_q    <= n_bc;
				acc_q   <= n_acc;
				dx_q    <= n_dx;
				dy_q    <= n_dy;
				dz_q    <= n_dz;
				etot_q  <= n_etot;
				ecnt_q  <= n_ecnt;
				col_q   <= n_col;
				vleft_q <= n_vleft;
				wait_q  <= n_wait;
			end
		end
	end

	// size product, one multiply per stage
	always_ff @(posedge clk) begin
		xy_q  <= 26'(dx_q) * 26'(dy_q);
		xyz_q <= 39'(xy_q) * 39'(dz_q);
	end

endmodule
`default_nettype wire

// ===== hw/rtl/vrvd_fifo.sv =====
// Result queue between parser and output: up to two writes, one read per cycle.
`default_nettype none
`include "voxel_rle_varint_decoder_macros.svh"
module vrvd_fifo #(
	parameter int unsigned DEPTH = vrvd_pkg::FIFO_DEPTH
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire  [1:0]     push_n,
	input  vrvd_pkg::res_t wr0,
	input  vrvd_pkg::res_t wr1,
	output logic           room2,
	output logic           rd_valid,
	input  wire            rd_ready,
	output vrvd_pkg::res_t rd_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	vrvd_pkg::res_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr_p1;
	logic [CW-1:0] cnt_q;
	logic          pop;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_p1    = inc(wr_q);
	assign rd_valid = cnt_q != '0;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_q];
	assign room2    = cnt_q <= CW'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= wr0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_p1] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_q <= wr_p1;
			end else if (push_n == 2'd2) begin
				wr_q <= inc(wr_p1);
			end
			if (pop) begin
				rd_q <= inc(rd_q);
			end
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

	`VRVD_ASSERT_NEVER(a_no_overflow, cnt_q > CW'(DEPTH), "result queue overflow")
	`VRVD_ASSERT_NEVER(a_push_room, (push_n != 2'd0) && !room2, "push without room")
	`VRVD_ASSERT_NEXT(a_pop_count, pop && (push_n == 2'd0), cnt_q == $past(cnt_q) - CW'(1),
		"count did not drop on pop")

endmodule
`default_nettype wire

// ===== hw/rtl/voxel_rle_varint_decoder.sv =====
// Voxel stream decoder top level: parser front end and result queue.
// Takes one stream byte per cycle; the only stall inside comes after
// the z size varint completes, while the registered x*y*z multiply settles.
// Each byte gives zero to two result words, queued in a small FIFO; a byte is
// taken only while two queue slots are free, so a slow output side stalls the
// input. Results are registered in the queue when their byte is taken.
`default_nettype none
module voxel_rle_varint_decoder #(
	parameter int unsigned FIFO_DEPTH = vrvd_pkg::FIFO_DEPTH
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [7:0]   s_axis_tdata,   // in_byte
	input  wire          s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// size_x, size_y, size_z, palette_count, palette_index, palette_color,
	// run_value, run_length, error_code, zero pad
	output logic [135:0] m_axis_tdata,
	output logic [2:0]   m_axis_tuser,   // kind
	output logic         m_axis_tlast    // last_result
);

	logic           room2;
	logic [1:0]     push_n;
	vrvd_pkg::res_t res0, res1, head;

	vrvd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_axis_tvalid),
		.byte_ready (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.last_byte  (s_axis_tlast),
		.room2      (room2),
		.push_n     (push_n),
		.res0       (res0),
		.res1       (res1)
	);

	vrvd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.wr0      (res0),
		.wr1      (res1),
		.room2    (room2),
		.rd_valid (m_axis_tvalid),
		.rd_ready (m_axis_tready),
		.rd_data  (head)
	);

	assign m_axis_tdata = {6'd0, head.error_code, head.run_length, head.run_value,
		head.palette_color, head.palette_index, head.palette_count,
		head.size_z, head.size_y, head.size_x};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last_result;

endmodule
`default_nettype wire

// ===== tb/tb_voxel_rle_varint_decoder.sv =====
// Self-checking testbench of the voxel stream decoder: directed table, then random streams.
`default_nettype none
module tb_voxel_rle_varint_decoder;

	typedef struct {
		logic [7:0]     b;
		bit             l;
		bit             typed;  // expected word typed in below instead of predicted
		bit             has;    // typed row gives one word (else none)
		vrvd_pkg::res_t e;
	} row_t;

	typedef struct {
		logic [7:0] b;
		bit         l;
	} sbyte_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 0;
	logic         s_axis_tlast = 0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [135:0] m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         m_axis_tlast;

	voxel_rle_varint_decoder DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #1 clk = ~clk;

	localparam logic [7:0] MAGIC [4] = '{8'h41, 8'h56, 8'h58, 8'h31};

	// decoder state as predicted
	vrvd_pkg::phase_t ph;
	int          bc;
	logic [63:0] acc;
	logic [12:0] dx, dy, dz;
	logic [8:0]  ptotal;
	int          pnum;
	logic [31:0] col;
	longint      vleft;

	vrvd_pkg::res_t want_words[$];
	row_t   rows[$];
	sbyte_t stream_bytes[$];
	int     errors = 0;
	int     idle_cycles = 0;
	bit     quiet_tx = 0, quiet_rx = 0;
	bit     big_palette_used = 0;

	function automatic vrvd_pkg::res_t blank(input logic [2:0] k);
		vrvd_pkg::res_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	function automatic vrvd_pkg::res_t err_word(input logic [2:0] code);
		vrvd_pkg::res_t r;
		r = blank(vrvd_pkg::KIND_ERROR);
		r.error_code = code;
		r.last_result = 1;
		return r;
	endfunction

	function automatic void clear_state();
		ph = vrvd_pkg::PH_MAGIC; bc = 0; acc = '0; dx = 0; dy = 0; dz = 0;
		ptotal = 0; pnum = 0; col = 0; vleft = 0;
	endfunction

	// 0 more bytes, 1 complete, 2 too long
	function automatic int varint_byte(input logic [7:0] b);
		acc = acc | (64'(b & 8'h7F) << (7 * bc));
		if (!b[7]) begin
			bc = 0;
			return 1;
		end
		if (bc >= 9) return 2;
		bc++;
		return 0;
	endfunction

	function automatic logic [12:0] dim_ok(input logic [63:0] v);
		return (v >= 1 && v <= vrvd_pkg::MAX_DIM) ? v[12:0] : 13'd0;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input bit lst, input bit keep);
		vrvd_pkg::res_t outq[$];
		vrvd_pkg::res_t r;
		int          vs;
		logic [63:0] v, len;
		logic [7:0]  idx;
		case (ph)
			vrvd_pkg::PH_MAGIC: begin
				if (b != MAGIC[bc & 3]) begin
					outq.insert(outq.size(), err_word(vrvd_pkg::ERR_MAGIC));
					ph = vrvd_pkg::PH_ERR;
				end else if (++bc >= 4) begin
					bc = 0; acc = 0; ph = vrvd_pkg::PH_VX;
				end
			end
			vrvd_pkg::PH_VX, vrvd_pkg::PH_VY, vrvd_pkg::PH_VZ, vrvd_pkg::PH_VP: begin
				vs = varint_byte(b);
				if (vs == 2) begin
					outq.insert(outq.size(), err_word(vrvd_pkg::ERR_TRUNC_HDR));
					ph = vrvd_pkg::PH_ERR;
				end else if (vs == 1) begin
					v = acc; acc = 0;
					if (ph == vrvd_pkg::PH_VX) begin
						dx = dim_ok(v); ph = vrvd_pkg::PH_VY;
					end else if (ph == vrvd_pkg::PH_VY) begin
						dy = dim_ok(v); ph = vrvd_pkg::PH_VZ;
					end else if (ph == vrvd_pkg::PH_VZ) begin
						dz = dim_ok(v); ph = vrvd_pkg::PH_VP;
					end else begin
						ptotal = (v >= 1 && v <= vrvd_pkg::MAX_PALETTE) ? v[8:0] : 9'd0;
						if (dx == 0 || dy == 0 || dz == 0 ||
							longint'(dx) * dy * dz > longint'(vrvd_pkg::MAX_VOXELS)) begin
							outq.insert(outq.size(), err_word(vrvd_pkg::ERR_SIZE));
							ph = vrvd_pkg::PH_ERR;
						end else if (ptotal == 0) begin
							outq.insert(outq.size(), err_word(vrvd_pkg::ERR_PALETTE));
							ph = vrvd_pkg::PH_ERR;
						end else begin
							vleft = longint'(dx) * dy * dz;
							r = blank(vrvd_pkg::KIND_HEADER);
							r.size_x = dx; r.size_y = dy; r.size_z = dz;
							r.palette_count = ptotal;
							outq.insert(outq.size(), r);
							pnum = 0; col = 0; bc = 0; ph = vrvd_pkg::PH_PAL;
						end
					end
				end
			end
			vrvd_pkg::PH_PAL: begin
				if (bc < 3) begin
					col = col | (32'(b) << (8 * bc));
					bc++;
				end else begin
					r = blank(vrvd_pkg::KIND_PALETTE);
					r.palette_index = pnum[7:0];
					r.palette_color = col | (32'(b) << 24);
					outq.insert(outq.size(), r);
					bc = 0; col = 0; pnum++;
					if (pnum >= ptotal) begin
						acc = 0; ph = vrvd_pkg::PH_RUNS;
					end
				end
			end
			vrvd_pkg::PH_RUNS: begin
				vs = varint_byte(b);
				if (vs == 2) begin
					outq.insert(outq.size(), err_word(vrvd_pkg::ERR_TRUNC_RUNS));
					ph = vrvd_pkg::PH_ERR;
				end else if (vs == 1) begin
					v = acc; acc = 0;
					idx = v[7:0];
					len = v >> 8;
					if (len == 0 || len > vleft) begin
						outq.insert(outq.size(), err_word(vrvd_pkg::ERR_RUN));
						ph = vrvd_pkg::PH_ERR;
					end else if (idx >= ptotal) begin
						outq.insert(outq.size(), err_word(vrvd_pkg::ERR_INDEX));
						ph = vrvd_pkg::PH_ERR;
					end else begin
						r = blank(vrvd_pkg::KIND_RUN);
						r.run_value = idx;
						r.run_length = len[30:0];
						outq.insert(outq.size(), r);
						vleft -= len;
						if (vleft == 0) ph = vrvd_pkg::PH_DONE;
					end
				end
			end
			vrvd_pkg::PH_DONE: begin
				outq.insert(outq.size(), err_word(vrvd_pkg::ERR_TRAILING));
				ph = vrvd_pkg::PH_ERR;
			end
			default: ;
		endcase
		if (lst) begin
			if (ph == vrvd_pkg::PH_DONE)
				outq.insert(outq.size(), blank(vrvd_pkg::KIND_DONE));
			else if (ph == vrvd_pkg::PH_MAGIC)
				outq.insert(outq.size(), err_word(vrvd_pkg::ERR_MAGIC));
			else if (ph == vrvd_pkg::PH_PAL)
				outq.insert(outq.size(), err_word(vrvd_pkg::ERR_PALETTE));
			else if (ph == vrvd_pkg::PH_RUNS)
				outq.insert(outq.size(), err_word(vrvd_pkg::ERR_TRUNC_RUNS));
			else if (ph != vrvd_pkg::PH_ERR)
				outq.insert(outq.size(), err_word(vrvd_pkg::ERR_TRUNC_HDR));
			clear_state();
		end
		foreach (outq[i]) begin
			outq[i].last_result = 0;
			if (i == outq.size() - 1) outq[i].last_result = 1;
			if (keep) want_words.insert(want_words.size(), outq[i]);
		end
	endtask

	task automatic add_row(input logic [7:0] b, input bit l, input bit typed,
		input bit has, input vrvd_pkg::res_t e);
		row_t r;
		r.b = b; r.l = l; r.typed = typed; r.has = has; r.e = e;
		rows.insert(rows.size(), r);
	endtask

	task automatic put_byte(input logic [7:0] b);
		sbyte_t s;
		s.b = b; s.l = 0;
		stream_bytes.insert(stream_bytes.size(), s);
	endtask

	task automatic put_varint(input longint unsigned v);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) begin
			repeat (10) put_byte(8'hFF);  // never terminates
			return;
		end
		while (v >= 128 || (r < 8 && v != 0)) begin
			put_byte({1'b1, v[6:0]});
			v = v >> 7;
		end
		if (r < 8) begin
			// redundant zero groups
			put_byte(8'h80);
		end
		put_byte({1'b0, v[6:0]});
	endtask

	function automatic longint pick_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 82) return $urandom_range(1, 4);
		if (r < 88) return 4096;
		if (r < 92) return $urandom_range(1, 4096);
		if (r < 95) return 0;
		if (r < 98) return 4097;
		return $urandom_range(5000, 200000);
	endfunction

	// one stream, mostly well formed, the rest damaged in some way
	task automatic add_stream();
		longint dxs, dys, dzs, pc, left, len, first;
		int     r, cut, nruns;
		dxs = pick_dim(); dys = pick_dim(); dzs = pick_dim();
		r = $urandom_range(0, 99);
		if (r < 88) pc = $urandom_range(1, 6);
		else if (r < 91 && !big_palette_used) begin
			pc = 256; big_palette_used = 1;
		end else if (r < 94) pc = 0;
		else if (r < 97) pc = 257;
		else pc = $urandom_range(1, 300);
		first = stream_bytes.size();
		foreach (MAGIC[i]) put_byte(MAGIC[i]);
		put_varint(dxs); put_varint(dys); put_varint(dzs); put_varint(pc);
		if (pc > 256) pc = 1;
		for (int i = 0; i < pc; i++)
			repeat (4) put_byte($urandom_range(0, 255));
		left = dxs * dys * dzs;
		if (left > 64'd1073741824 || left == 0) left = $urandom_range(1, 8);
		nruns = 0;
		while (left > 0) begin
			r = $urandom_range(0, 99);
			if (nruns >= 5 || r < 25) len = left;
			else len = $urandom_range(1, (left > 8) ? 8 : left);
			if (r >= 97) len = (r == 99) ? 0 : left + 1;
			put_varint({len, 8'($urandom_range(0, 99) < 96 ?
				$urandom_range(0, pc - 1) : $urandom_range(0, 255))});
			if (len == 0 || len > left) break;
			left -= len;
			nruns++;
		end
		r = $urandom_range(0, 99);
		if (r >= 70 && r < 80) begin
			cut = $urandom_range(first, stream_bytes.size() - 1);
			stream_bytes[cut].b = $urandom_range(0, 255);
		end else if (r >= 80 && r < 90) begin
			cut = $urandom_range(first, stream_bytes.size() - 1);
			while (stream_bytes.size() > cut + 1) void'(stream_bytes.pop_back());
		end else if (r >= 90) begin
			repeat ($urandom_range(1, 3)) put_byte($urandom_range(0, 255));
		end
		stream_bytes[stream_bytes.size() - 1].l = 1;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// input side: one byte per call
	task automatic send_byte(input logic [7:0] b, input bit l);
		int g;
		g = quiet_tx ? 0 : gap_len();
		if (g > 0) begin
			s_axis_tvalid = 0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tdata = b;
		s_axis_tlast = l;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic chk(input string name, input longint e, input longint a);
		if (e != a) begin
			$display("%0t: %s expected %0h got %0h", $time, name, e, a);
			errors++;
		end
	endtask

	// output side
	initial begin
		vrvd_pkg::res_t act, e;
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (!arst_n) continue;
			if (stall > 0) begin
				stall--;
				m_axis_tready = 0;
			end else begin
				m_axis_tready = 1;
				if (!quiet_rx) stall = gap_len();
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				act = '0;
				act.size_x        = m_axis_tdata[12:0];
				act.size_y        = m_axis_tdata[25:13];
				act.size_z        = m_axis_tdata[38:26];
				act.palette_count = m_axis_tdata[47:39];
				act.palette_index = m_axis_tdata[55:48];
				act.palette_color = m_axis_tdata[87:56];
				act.run_value     = m_axis_tdata[95:88];
				act.run_length    = m_axis_tdata[126:96];
				act.error_code    = m_axis_tdata[129:127];
				act.kind          = m_axis_tuser;
				act.last_result   = m_axis_tlast;
				if (m_axis_tdata[135:130] != 0)
					chk("pad", 0, m_axis_tdata[135:130]);
				if (want_words.size() == 0) begin
					$display("%0t: expected no word got word kind %0d", $time, act.kind);
					errors++;
				end else begin
					e = want_words.pop_front();
					chk("kind", e.kind, act.kind);
					chk("size_x", e.size_x, act.size_x);
					chk("size_y", e.size_y, act.size_y);
					chk("size_z", e.size_z, act.size_z);
					chk("palette_count", e.palette_count, act.palette_count);
					chk("palette_index", e.palette_index, act.palette_index);
					chk("palette_color", e.palette_color, act.palette_color);
					chk("run_value", e.run_value, act.run_value);
					chk("run_length", e.run_length, act.run_length);
					chk("error_code", e.error_code, act.error_code);
					chk("last_result", e.last_result, act.last_result);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 5000) begin
			$display("voxel_rle_varint_decoder: mismatch");
			$finish;
		end
	end

	initial begin
		vrvd_pkg::res_t h, none;
		clear_state();
		none = '0;
		h = blank(vrvd_pkg::KIND_HEADER);
		h.size_x = 4096; h.size_y = 1; h.size_z = 1; h.palette_count = 256;
		h.last_result = 1;
		add_row("Z", 0, 1, 1, err_word(vrvd_pkg::ERR_MAGIC));
		add_row(8'h00, 1, 1, 0, none);               // ignored after error
		add_row("A", 1, 1, 1, err_word(vrvd_pkg::ERR_MAGIC));  // stream ends inside magic
		foreach (MAGIC[i]) add_row(MAGIC[i], 0, 1, 0, none);
		add_row(8'h80, 0, 1, 0, none);               // x = 4096
		add_row(8'h20, 0, 1, 0, none);
		add_row(8'h01, 0, 1, 0, none);
		add_row(8'h01, 0, 1, 0, none);
		add_row(8'h80, 0, 1, 0, none);               // 256 palette entries
		add_row(8'h02, 0, 1, 1, h);
		repeat (4) add_row(8'hFF, 0, 0, 0, none);
		add_row(8'h00, 1, 1, 1, err_word(vrvd_pkg::ERR_PALETTE));  // short palette
		add_row(8'h00, 1, 1, 1, err_word(vrvd_pkg::ERR_MAGIC));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (rows[i]) begin
			send_byte(rows[i].b, rows[i].l);
			decode_byte(rows[i].b, rows[i].l, !rows[i].typed);
			if (rows[i].typed && rows[i].has)
				want_words.insert(want_words.size(), rows[i].e);
		end

		while (stream_bytes.size() < 1850) add_stream();
		foreach (stream_bytes[i]) begin
			if (i % 200 == 0) begin
				quiet_tx = ($urandom_range(0, 3) == 0);
				quiet_rx = ($urandom_range(0, 3) == 0);
			end
			send_byte(stream_bytes[i].b, stream_bytes[i].l);
			decode_byte(stream_bytes[i].b, stream_bytes[i].l, 1);
		end
		s_axis_tvalid = 0;
		while (want_words.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("voxel_rle_varint_decoder: match");
		else
			$display("voxel_rle_varint_decoder: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
